[hw/rtl/lstr_pkg.sv]
package lstr_pkg;

  // datapath width of the shared unit, wide enough for the largest set
  localparam int unsigned ALU_W          = 64;
  localparam int unsigned CNT_W          = $clog2(ALU_W);
  localparam int unsigned PORT_XW        = 12;
  localparam int unsigned RES_W          = 32;
  localparam int unsigned DEF_MAX_POINTS = 64;
  localparam int unsigned DEF_COORD_BITS = 12;
  localparam int unsigned FRAC_BITS      = 16;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef enum logic [3:0] {
    S_ACC,
    S_MUL_SXX,
    S_DIV_SXX,
    S_MUL_SXY,
    S_DIV_SXY,
    S_DIV_MX,
    S_DIV_MY,
    S_MUL_BASE,
    S_MUL_T1,
    S_DIV_Y1,
    S_MUL_T2,
    S_DIV_Y2,
    S_DIV_G,
    S_OUT
  } seq_state_t;

  // sign and magnitude to a saturated signed 32-bit value
  function automatic logic [RES_W-1:0] sat32(input logic neg, input logic [ALU_W-1:0] mag);
    logic [ALU_W-1:0] lim_pos;
    logic [ALU_W-1:0] lim_neg;
    logic [ALU_W-1:0] neg_val;
    lim_pos = ALU_W'(32'h7fff_ffff);
    lim_neg = ALU_W'(33'h1_0000_0000 >> 1);
    neg_val = ~mag + ALU_W'(1);
    if (!neg) begin
      return (mag > lim_pos) ? RES_W'(32'h7fff_ffff) : mag[RES_W-1:0];
    end else begin
      return (mag > lim_neg) ? RES_W'(32'h8000_0000) : neg_val[RES_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/least_squares_trendline_core.sv]
// Least-squares trendline over a set of points. Points are taken one per cycle while busy is
// low (start high); the request with in_last_point set closes the set. Each taken point is
// folded into the count and the sums of x, y, x*x and x*y in that cycle. After the last point
// busy stays high while a single shared multiply/divide unit, one bit per cycle over 64 bits,
// works through the fit: twelve operations for a normal set and two for a degenerate one. The
// result then appears for exactly one cycle with out_valid high; the receiver cannot stall it,
// so it must take it in that cycle. Points beyond MAX_POINTS are dropped and flagged.
module least_squares_trendline_core #(
  parameter int unsigned MAX_POINTS = lstr_pkg::DEF_MAX_POINTS,
  parameter int unsigned COORD_BITS = lstr_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lstr_pkg::PORT_XW-1:0]      in_x_value,
  input  logic [lstr_pkg::PORT_XW-1:0]      in_y_value,
  input  logic                              in_last_point,
  output logic                              out_valid,
  output logic [lstr_pkg::PORT_XW-1:0]      out_start_x,
  output logic signed [lstr_pkg::RES_W-1:0] out_start_y,
  output logic [lstr_pkg::PORT_XW-1:0]      out_end_x,
  output logic signed [lstr_pkg::RES_W-1:0] out_end_y,
  output logic signed [lstr_pkg::RES_W-1:0] out_gradient_q16,
  output logic                              out_degenerate,
  output logic                              out_overflowed
);

  localparam int unsigned W  = lstr_pkg::ALU_W;
  // coordinate bits actually used: the port carries at most PORT_XW
  localparam int unsigned XB = (COORD_BITS < lstr_pkg::PORT_XW) ? COORD_BITS
                                                                : lstr_pkg::PORT_XW;
  localparam int unsigned NB = $clog2(MAX_POINTS + 1);
  localparam int unsigned SB = XB + NB;       // sum of x or y
  localparam int unsigned QB = 2 * XB + NB;   // sum of x*x or x*y

  lstr_pkg::seq_state_t state_r, state_nxt;
  logic                 wait_r, wait_nxt;

  // accumulators for the open set
  logic [NB-1:0] count_r, count_nxt;
  logic [SB-1:0] sum_x_r, sum_x_nxt;
  logic [SB-1:0] sum_y_r, sum_y_nxt;
  logic [QB-1:0] sum_xx_r, sum_xx_nxt;
  logic [QB-1:0] sum_xy_r, sum_xy_nxt;
  logic [XB-1:0] first_x_r, first_x_nxt;
  logic [XB-1:0] end_x_r, end_x_nxt;
  logic          ovf_r, ovf_nxt;

  // fit intermediates
  logic [W-1:0]        tmp_r, tmp_nxt;
  logic [W-1:0]        sxx_r, sxx_nxt;
  logic signed [W-1:0] sxy_r, sxy_nxt;
  logic [XB-1:0]       mx_r, mx_nxt;
  logic [XB-1:0]       my_r, my_nxt;
  logic [W-1:0]        base_r, base_nxt;
  logic                tneg_r, tneg_nxt;
  logic signed [W-1:0] num_r, num_nxt;
  logic [lstr_pkg::RES_W-1:0] y1_r, y1_nxt;
  logic [lstr_pkg::RES_W-1:0] y2_r, y2_nxt;
  logic [lstr_pkg::RES_W-1:0] grad_r, grad_nxt;
  logic          degen_r, degen_nxt;

  // shared unit hookup
  logic              alu_go;
  lstr_pkg::alu_op_t alu_op;
  logic [W-1:0]      alu_a;
  logic [W-1:0]      alu_b;
  logic              alu_done;
  logic [W-1:0]      alu_res;

  logic [XB-1:0]  x_in;
  logic [XB-1:0]  y_in;
  logic           take;
  logic [W-1:0]   n_ext;
  logic [W-1:0]   sx_ext;
  logic [W-1:0]   sy_ext;
  logic [W-1:0]   sxy_mag;
  logic [XB-1:0]  t_x;
  logic [XB-1:0]  dx_mag;
  logic           dx_neg;
  logic           rnd_neg;
  logic [W-1:0]   rnd_mag;
  logic [W-1:0]   num_mag;

  assign x_in   = in_x_value[XB-1:0];
  assign y_in   = in_y_value[XB-1:0];
  assign busy   = (state_r != lstr_pkg::S_ACC);
  assign take   = start && !busy;
  assign n_ext  = W'(count_r);
  assign sx_ext = W'(sum_x_r);
  assign sy_ext = W'(sum_y_r);

  // magnitude of sxy and of (x - mean_x) for the sign-magnitude multiplies
  assign sxy_mag = sxy_r[W-1] ? W'(-sxy_r) : W'(sxy_r);
  assign t_x     = (state_r == lstr_pkg::S_MUL_T2) ? end_x_r : first_x_r;
  assign dx_neg  = (t_x < mx_r);
  assign dx_mag  = dx_neg ? (mx_r - t_x) : (t_x - mx_r);
  assign num_mag = num_r[W-1] ? W'(-num_r) : W'(num_r);

  // rounded divides: (2*mag + sxx) / (2*sxx)
  always_comb begin
    if (state_r == lstr_pkg::S_DIV_G) begin
      rnd_neg = sxy_r[W-1];
      rnd_mag = sxy_mag << lstr_pkg::FRAC_BITS;
    end else begin
      rnd_neg = num_r[W-1];
      rnd_mag = num_mag;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wait_nxt    = wait_r;
    count_nxt   = count_r;
    sum_x_nxt   = sum_x_r;
    sum_y_nxt   = sum_y_r;
    sum_xx_nxt  = sum_xx_r;
    sum_xy_nxt  = sum_xy_r;
    first_x_nxt = first_x_r;
    end_x_nxt   = end_x_r;
    ovf_nxt     = ovf_r;
    tmp_nxt     = tmp_r;
    sxx_nxt     = sxx_r;
    sxy_nxt     = sxy_r;
    mx_nxt      = mx_r;
    my_nxt      = my_r;
    base_nxt    = base_r;
    tneg_nxt    = tneg_r;
    num_nxt     = num_r;
    y1_nxt      = y1_r;
    y2_nxt      = y2_r;
    grad_nxt    = grad_r;
    degen_nxt   = degen_r;
    alu_go      = 1'b0;
    alu_op      = lstr_pkg::OP_MUL;
    alu_a       = '0;
    alu_b       = '0;

    // operands per step
    case (state_r)
      lstr_pkg::S_MUL_SXX: begin
        alu_a = sx_ext;
        alu_b = sx_ext;
      end
      lstr_pkg::S_MUL_SXY: begin
        alu_a = sx_ext;
        alu_b = sy_ext;
      end
      lstr_pkg::S_DIV_SXX, lstr_pkg::S_DIV_SXY: begin
        alu_op = lstr_pkg::OP_DIV;
        alu_a  = tmp_r;
        alu_b  = n_ext;
      end
      lstr_pkg::S_DIV_MX: begin
        alu_op = lstr_pkg::OP_DIV;
        alu_a  = sx_ext;
        alu_b  = n_ext;
      end
      lstr_pkg::S_DIV_MY: begin
        alu_op = lstr_pkg::OP_DIV;
        alu_a  = sy_ext;
        alu_b  = n_ext;
      end
      lstr_pkg::S_MUL_BASE: begin
        alu_a = W'(my_r);
        alu_b = sxx_r;
      end
      lstr_pkg::S_MUL_T1, lstr_pkg::S_MUL_T2: begin
        alu_a = W'(dx_mag);
        alu_b = sxy_mag;
      end
      lstr_pkg::S_DIV_Y1, lstr_pkg::S_DIV_Y2, lstr_pkg::S_DIV_G: begin
        alu_op = lstr_pkg::OP_DIV;
        alu_a  = {rnd_mag[W-2:0], 1'b0} + sxx_r;
        alu_b  = {sxx_r[W-2:0], 1'b0};
      end
      default: begin
        alu_a = '0;
      end
    endcase

    // every fit step launches once, then waits for done
    if (busy && state_r != lstr_pkg::S_OUT && !wait_r) begin
      alu_go   = 1'b1;
      wait_nxt = 1'b1;
    end

    case (state_r)
      lstr_pkg::S_ACC: begin
        if (take) begin
          end_x_nxt = x_in;
          if (count_r < NB'(MAX_POINTS)) begin
            if (count_r == '0) first_x_nxt = x_in;
            count_nxt  = count_r + NB'(1);
            sum_x_nxt  = sum_x_r + SB'(x_in);
            sum_y_nxt  = sum_y_r + SB'(y_in);
            sum_xx_nxt = sum_xx_r + QB'(x_in * x_in);
            sum_xy_nxt = sum_xy_r + QB'(x_in * y_in);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_point) begin
            state_nxt = lstr_pkg::S_MUL_SXX;
            wait_nxt  = 1'b0;
          end
        end
      end
      lstr_pkg::S_MUL_SXX: begin
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = lstr_pkg::S_DIV_SXX;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_SXX: begin
        if (alu_done) begin
          sxx_nxt  = W'(sum_xx_r) - alu_res;
          wait_nxt = 1'b0;
          // zero spread in x or an empty set: nothing more to compute
          if (W'(sum_xx_r) == alu_res || count_r == '0) begin
            degen_nxt = 1'b1;
            y1_nxt    = '0;
            y2_nxt    = '0;
            grad_nxt  = '0;
            state_nxt = lstr_pkg::S_OUT;
          end else begin
            degen_nxt = 1'b0;
            state_nxt = lstr_pkg::S_MUL_SXY;
          end
        end
      end
      lstr_pkg::S_MUL_SXY: begin
        if (alu_done) begin
          tmp_nxt   = alu_res;
          state_nxt = lstr_pkg::S_DIV_SXY;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_SXY: begin
        if (alu_done) begin
          sxy_nxt   = $signed(W'(sum_xy_r)) - $signed(alu_res);
          state_nxt = lstr_pkg::S_DIV_MX;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_MX: begin
        if (alu_done) begin
          mx_nxt    = alu_res[XB-1:0];
          state_nxt = lstr_pkg::S_DIV_MY;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_MY: begin
        if (alu_done) begin
          my_nxt    = alu_res[XB-1:0];
          state_nxt = lstr_pkg::S_MUL_BASE;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_MUL_BASE: begin
        if (alu_done) begin
          base_nxt  = alu_res;
          state_nxt = lstr_pkg::S_MUL_T1;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_MUL_T1, lstr_pkg::S_MUL_T2: begin
        // sign of the product is latched at launch
        if (alu_go) tneg_nxt = sxy_r[W-1] ^ dx_neg;
        if (alu_done) begin
          num_nxt   = tneg_r ? $signed(base_r - alu_res) : $signed(base_r + alu_res);
          state_nxt = (state_r == lstr_pkg::S_MUL_T1) ? lstr_pkg::S_DIV_Y1
                                                      : lstr_pkg::S_DIV_Y2;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_Y1: begin
        if (alu_done) begin
          y1_nxt    = lstr_pkg::sat32(rnd_neg, alu_res);
          state_nxt = lstr_pkg::S_MUL_T2;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_Y2: begin
        if (alu_done) begin
          y2_nxt    = lstr_pkg::sat32(rnd_neg, alu_res);
          state_nxt = lstr_pkg::S_DIV_G;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_DIV_G: begin
        if (alu_done) begin
          grad_nxt  = lstr_pkg::sat32(rnd_neg, alu_res);
          state_nxt = lstr_pkg::S_OUT;
          wait_nxt  = 1'b0;
        end
      end
      lstr_pkg::S_OUT: begin
        // result shown this cycle, then the set starts over
        state_nxt   = lstr_pkg::S_ACC;
        wait_nxt    = 1'b0;
        count_nxt   = '0;
        sum_x_nxt   = '0;
        sum_y_nxt   = '0;
        sum_xx_nxt  = '0;
        sum_xy_nxt  = '0;
        first_x_nxt = '0;
        ovf_nxt     = 1'b0;
      end
      default: begin
        state_nxt = lstr_pkg::S_ACC;
        wait_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lstr_pkg::S_ACC;
      wait_r    <= 1'b0;
      count_r   <= '0;
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_xx_r  <= '0;
      sum_xy_r  <= '0;
      first_x_r <= '0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wait_r    <= wait_nxt;
      count_r   <= count_nxt;
      sum_x_r   <= sum_x_nxt;
      sum_y_r   <= sum_y_nxt;
      sum_xx_r  <= sum_xx_nxt;
      sum_xy_r  <= sum_xy_nxt;
      first_x_r <= first_x_nxt;
      ovf_r     <= ovf_nxt;
    end
    end_x_r <= end_x_nxt;
    tmp_r   <= tmp_nxt;
    sxx_r   <= sxx_nxt;
    sxy_r   <= sxy_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    base_r  <= base_nxt;
    tneg_r  <= tneg_nxt;
    num_r   <= num_nxt;
    y1_r    <= y1_nxt;
    y2_r    <= y2_nxt;
    grad_r  <= grad_nxt;
    degen_r <= degen_nxt;
  end

  lstr_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (alu_go),
    .op     (alu_op),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  // result request, one cycle wide
  assign out_valid        = (state_r == lstr_pkg::S_OUT);
  assign out_start_x      = degen_r ? '0 : lstr_pkg::PORT_XW'(first_x_r);
  assign out_end_x        = degen_r ? '0 : lstr_pkg::PORT_XW'(end_x_r);
  assign out_start_y      = $signed(y1_r);
  assign out_end_y        = $signed(y2_r);
  assign out_gradient_q16 = $signed(grad_r);
  assign out_degenerate   = degen_r;
  assign out_overflowed   = ovf_r;

endmodule

[hw/rtl/lstr_alu.sv]
module lstr_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  lstr_pkg::alu_op_t           op,
  input  logic [lstr_pkg::ALU_W-1:0]  opa,
  input  logic [lstr_pkg::ALU_W-1:0]  opb,
  output logic                        done,
  output logic [lstr_pkg::ALU_W-1:0]  result
);

  localparam int unsigned W  = lstr_pkg::ALU_W;
  localparam int unsigned CW = lstr_pkg::CNT_W;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  lstr_pkg::alu_op_t op_r, op_nxt;
  logic [W-1:0]      acc_r, acc_nxt;
  logic [W-1:0]      a_r, a_nxt;
  logic [W-1:0]      b_r, b_nxt;
  logic [W-1:0]      rem_sh;
  logic              fits;

  // shift-add multiply or restoring divide, one bit per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_sh   = {acc_r[W-2:0], a_r[W-1]};
    fits     = (rem_sh >= b_r);
    if (go && !run_r) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      op_nxt  = op;
      acc_nxt = '0;
      a_nxt   = opa;
      b_nxt   = opb;
    end else if (run_r) begin
      case (op_r)
        lstr_pkg::OP_MUL: begin
          if (a_r[0]) acc_nxt = acc_r + b_r;
          a_nxt = {1'b0, a_r[W-1:1]};
          b_nxt = {b_r[W-2:0], 1'b0};
        end
        lstr_pkg::OP_DIV: begin
          acc_nxt = fits ? rem_sh - b_r : rem_sh;
          a_nxt   = {a_r[W-2:0], fits};
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= lstr_pkg::OP_MUL;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done   = done_r;
  assign result = (op_r == lstr_pkg::OP_MUL) ? acc_r : a_r;

endmodule
